// ----- design/tubb_pkg.sv -----
package tubb_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned BITPOS_W   = 3;

    localparam logic [BITPOS_W-1:0] STATUS_CMD_BIT = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CASSETTE_PRESENT = 3'd0,
        CFG_WRITE_PROTECT    = 3'd1,
        CFG_CMD_WRITE_START  = 3'd2,
        CFG_CMD_READ_START   = 3'd3,
        CFG_CMD_STOP         = 3'd4,
        CFG_BIT_NO_CASSETTE  = 3'd5,
        CFG_BIT_PROTECTED    = 3'd6,
        CFG_BIT_BUFFER_FULL  = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_WRITE = 2'd1,
        RUN_READ  = 2'd2
    } t_run_mode;

    localparam logic [BYTE_W-1:0] RST_CMD_WRITE_START = 8'h01;
    localparam logic [BYTE_W-1:0] RST_CMD_READ_START  = 8'h02;
    localparam logic [BYTE_W-1:0] RST_CMD_STOP        = 8'h03;
    localparam logic [BITPOS_W-1:0] RST_BIT_NO_CASSETTE = 3'd7;
    localparam logic [BITPOS_W-1:0] RST_BIT_PROTECTED   = 3'd6;
    localparam logic [BITPOS_W-1:0] RST_BIT_BUFFER_FULL = 3'd0;

endpackage

// ----- design/tubb_in_if.sv -----
interface tubb_in_if
    import tubb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic              port_select;
    logic [BYTE_W-1:0] write_byte;

    modport source (output valid, output mode, output port_select, output write_byte,
                    input ready);
    modport sink (input valid, input mode, input port_select, input write_byte,
                  output ready);
endinterface

// ----- design/tubb_out_if.sv -----
interface tubb_out_if
    import tubb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic [LEN_W-1:0]  recorded_length;

    modport source (output valid, output read_byte, output recorded_length,
                    input ready);
    modport sink (input valid, input read_byte, input recorded_length,
                  output ready);
endinterface

// ----- design/tape_unit_byte_buffer_device.sv -----
// Tape unit byte buffer device: a data port and a command/status port in front of a
// STORE_DEPTH-byte single-port tape store with one wrapping position. One transaction
// is accepted per clock cycle unless the sweep runs or the output stalls. Its result
// waits in the A register (the synchronous store read happens at the accepting edge)
// and moves to the output register B when B is empty or being taken. The single
// store port serves one access per cycle, which sets the rate. After reset the store
// is swept to zero, one byte per cycle, so no transaction is accepted until the sweep
// has ended; configuration writes are taken during that time.
module tape_unit_byte_buffer_device
    import tubb_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tubb_in_if.sink               i_in,
    tubb_out_if.source            o_out
);

    localparam int unsigned PW = $clog2(STORE_DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(STORE_DEPTH - 1);

    // configuration
    logic                r_cassette;
    logic                r_protect;
    logic [BYTE_W-1:0]   r_cmd_ws;
    logic [BYTE_W-1:0]   r_cmd_rs;
    logic [BYTE_W-1:0]   r_cmd_stop;
    logic [BITPOS_W-1:0] r_bit_nocas;
    logic [BITPOS_W-1:0] r_bit_prot;
    logic [BITPOS_W-1:0] r_bit_full;

    // device state
    logic [PW-1:0]    r_pos,      n_pos;
    logic [LEN_W-1:0] r_len,      n_len;
    t_run_mode        r_run,      n_run;
    logic             r_cmd_flag, n_cmd_flag;
    logic             r_full,     n_full;

    // clearing sweep
    logic          r_clr_busy;
    logic [PW-1:0] r_clr_addr;

    // store
    logic [BYTE_W-1:0] tape_store [STORE_DEPTH];
    logic [BYTE_W-1:0] r_mem_q;
    logic              mem_we;
    logic              mem_re;
    logic [PW-1:0]     mem_wa;
    logic [BYTE_W-1:0] mem_wd;

    // pipeline
    logic              r_a_valid;
    logic              r_a_dread,  n_a_dread;
    logic [BYTE_W-1:0] r_a_byte,   n_a_byte;
    logic [LEN_W-1:0]  r_a_len;
    logic              r_b_valid;
    logic [BYTE_W-1:0] r_b_byte;
    logic [LEN_W-1:0]  r_b_len;

    logic              in_acc;
    logic              a_move;
    logic [PW-1:0]     pos_inc;
    logic [PW+LEN_W-1:0] pos_ext;
    logic [BYTE_W-1:0] status;

    assign i_in.ready = !r_clr_busy && (!r_a_valid || !r_b_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign a_move     = r_a_valid && (!r_b_valid || o_out.ready);

    assign o_out.valid           = r_b_valid;
    assign o_out.read_byte       = r_b_byte;
    assign o_out.recorded_length = r_b_len;

    assign pos_inc = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
    assign pos_ext = {{LEN_W{1'b0}}, r_pos};

    always_comb begin
        status = '0;
        status[STATUS_CMD_BIT] = r_cmd_flag;
        if (!r_cassette) begin
            status[r_bit_nocas] = 1'b1;
        end
        if (r_cassette && r_protect) begin
            status[r_bit_prot] = 1'b1;
        end
        if (r_full) begin
            status[r_bit_full] = 1'b1;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_run      = r_run;
        n_cmd_flag = r_cmd_flag;
        n_full     = r_full;
        n_a_dread  = 1'b0;
        n_a_byte   = '0;
        mem_re     = 1'b0;
        mem_we     = r_clr_busy;
        mem_wa     = r_clr_addr;
        mem_wd     = '0;
        if (in_acc) begin
            if (i_in.mode) begin
                if (i_in.port_select) begin
                    n_cmd_flag = 1'b1;
                    if (i_in.write_byte == r_cmd_ws) begin
                        n_full = 1'b0;
                        n_pos  = '0;
                        n_run  = RUN_WRITE;
                    end else if (i_in.write_byte == r_cmd_rs) begin
                        n_full = 1'b1;
                        n_pos  = '0;
                        n_run  = RUN_READ;
                    end else if (i_in.write_byte == r_cmd_stop) begin
                        n_len = (r_run == RUN_WRITE) ? pos_ext[LEN_W-1:0] : '0;
                    end
                end else begin
                    n_cmd_flag = 1'b0;
                    mem_we     = 1'b1;
                    mem_wa     = r_pos;
                    mem_wd     = i_in.write_byte;
                    n_pos      = pos_inc;
                end
            end else begin
                if (i_in.port_select) begin
                    n_a_byte = status;
                end else begin
                    mem_re    = 1'b1;
                    n_a_dread = 1'b1;
                    n_pos     = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            tape_store[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= tape_store[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_POS) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cassette  <= 1'b0;
            r_protect   <= 1'b0;
            r_cmd_ws    <= RST_CMD_WRITE_START;
            r_cmd_rs    <= RST_CMD_READ_START;
            r_cmd_stop  <= RST_CMD_STOP;
            r_bit_nocas <= RST_BIT_NO_CASSETTE;
            r_bit_prot  <= RST_BIT_PROTECTED;
            r_bit_full  <= RST_BIT_BUFFER_FULL;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CASSETTE_PRESENT: r_cassette  <= i_cfg_data[0];
                CFG_WRITE_PROTECT:    r_protect   <= i_cfg_data[0];
                CFG_CMD_WRITE_START:  r_cmd_ws    <= i_cfg_data[BYTE_W-1:0];
                CFG_CMD_READ_START:   r_cmd_rs    <= i_cfg_data[BYTE_W-1:0];
                CFG_CMD_STOP:         r_cmd_stop  <= i_cfg_data[BYTE_W-1:0];
                CFG_BIT_NO_CASSETTE:  r_bit_nocas <= i_cfg_data[BITPOS_W-1:0];
                CFG_BIT_PROTECTED:    r_bit_prot  <= i_cfg_data[BITPOS_W-1:0];
                CFG_BIT_BUFFER_FULL:  r_bit_full  <= i_cfg_data[BITPOS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_run      <= RUN_IDLE;
            r_cmd_flag <= 1'b0;
            r_full     <= 1'b0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_run      <= n_run;
            r_cmd_flag <= n_cmd_flag;
            r_full     <= n_full;
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_dread <= n_a_dread;
            r_a_byte  <= n_a_byte;
            r_a_len   <= n_len;
        end
        if (a_move) begin
            r_b_byte <= r_a_dread ? r_mem_q : r_a_byte;
            r_b_len  <= r_a_len;
        end
    end

endmodule

// ----- design/tubb_checker.sv -----
module tubb_checker
    import tubb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_read_byte,
    input logic [LEN_W-1:0]  i_recorded_length
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // store sweep blocks transactions right after reset
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // a new result needs an earlier accepted transaction
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 2))
        else $error("result without accepted transaction");

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_read_byte) && $stable(i_recorded_length))
        else $error("result changed while stalled");

endmodule

bind tape_unit_byte_buffer_device tubb_checker u_tubb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_read_byte       (o_out.read_byte),
    .i_recorded_length (o_out.recorded_length)
);
